[rtl/uvs_pkg.sv]
// uvs_pkg: shared widths, sine coefficients, rounding helpers and types
// for the uv sphere vertex generator; depends on nothing
package uvs_pkg;

  localparam int DIVISION_BITS_DEF        = 8;
  localparam int NORMAL_FRACTION_BITS_DEF = 15;

  // divider cell word: remainder field on top, quotient shifts in from the bottom
  localparam int DIV_QW = 17;
  localparam int DIV_DW = 9;
  localparam int DIV_RW = DIV_DW + 1;
  localparam int DIV_WW = DIV_RW + DIV_QW;

  // sine lane depth: mirror, square, six horner cells, final product
  localparam int SIN_LAT = 9;

  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [31:0] QUARTER   = 32'h4000_0000;
  localparam logic signed [63:0] POS_LIM = 64'sd16777215;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_RINGS  = 2'd1;
  localparam logic [1:0] REG_SLICES = 2'd2;

  typedef struct packed {
    logic [1:0]  quad;
    logic [30:0] t;
    logic [30:0] t2;
    logic [30:0] acc;
  } sin_t;

  typedef struct packed {
    logic        point_valid;
    logic        quad_start;
    logic [15:0] vertex_index;
    logic [15:0] below_index;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } band_t;

  function automatic logic [30:0] sine_coef(input int k);
    logic [30:0] c;
    unique case (k)
      0: c = 31'd1686629713;
      1: c = 31'd693598668;
      2: c = 31'd85569306;
      3: c = 31'd5026995;
      4: c = 31'd172272;
      5: c = 31'd3864;
      default: c = 31'd61;
    endcase
    return c;
  endfunction

  // shift right with rounding half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int sh);
    logic        neg;
    logic [63:0] m;
    neg = v[63];
    m = neg ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim);
    logic signed [63:0] r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

endpackage

[rtl/uvs_div_cell.sv]
// uvs_div_cell: one restoring division step, one quotient bit per cycle
// depends on uvs_pkg
module uvs_div_cell (
  input  logic                        clk,
  input  logic [uvs_pkg::DIV_DW-1:0]  divisor,
  input  logic [uvs_pkg::DIV_WW-1:0]  din,
  output logic [uvs_pkg::DIV_WW-1:0]  dout
);

  logic [uvs_pkg::DIV_WW-1:0] sh;
  logic [uvs_pkg::DIV_WW-1:0] nxt;
  logic [uvs_pkg::DIV_RW-1:0] top;

  always_comb begin
    sh  = {din[uvs_pkg::DIV_WW-2:0], 1'b0};
    top = sh[uvs_pkg::DIV_WW-1:uvs_pkg::DIV_QW];
    nxt = sh;
    if (top >= {1'b0, divisor}) begin
      nxt[uvs_pkg::DIV_WW-1:uvs_pkg::DIV_QW] = top - {1'b0, divisor};
      nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

[rtl/uvs_sin_cell.sv]
// uvs_sin_cell: one horner step of the sine polynomial
// depends on uvs_pkg
module uvs_sin_cell #(
  parameter int K = 0
) (
  input  logic          clk,
  input  uvs_pkg::sin_t din,
  output uvs_pkg::sin_t dout
);

  logic [61:0] prod;

  assign prod = din.t2 * din.acc;

  always_ff @(posedge clk) begin
    dout.quad <= din.quad;
    dout.t    <= din.t;
    dout.t2   <= din.t2;
    dout.acc  <= uvs_pkg::sine_coef(K) - prod[60:30];
  end

endmodule

[rtl/uvs_sin_lane.sv]
// uvs_sin_lane: q30 sine of a 32 bit phase as a chain of horner cells
// depends on uvs_pkg and uvs_sin_cell
module uvs_sin_lane (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [31:0] sine
);

  logic [1:0]    quad1;
  logic [30:0]   t1;
  logic [61:0]   sq;
  logic [61:0]   fin;
  logic [31:0]   mag;
  uvs_pkg::sin_t s [7];

  // quadrant and mirrored offset
  always_ff @(posedge clk) begin
    quad1 <= phase[31:30];
    if (phase[30]) begin
      t1 <= uvs_pkg::Q30_ONE - {1'b0, phase[29:0]};
    end else begin
      t1 <= {1'b0, phase[29:0]};
    end
  end

  assign sq = t1 * t1;

  always_ff @(posedge clk) begin
    s[0].quad <= quad1;
    s[0].t    <= t1;
    s[0].t2   <= sq[60:30];
    s[0].acc  <= uvs_pkg::sine_coef(6);
  end

  for (genvar i = 0; i < 6; i++) begin : g_cell
    uvs_sin_cell #(.K(5 - i)) u_cell (
      .clk  (clk),
      .din  (s[i]),
      .dout (s[i+1])
    );
  end

  assign fin = s[6].t * s[6].acc;

  always_comb begin
    mag = fin[61:30];
    if (mag > {1'b0, uvs_pkg::Q30_ONE}) mag = {1'b0, uvs_pkg::Q30_ONE};
  end

  always_ff @(posedge clk) begin
    if (s[6].quad[1]) begin
      sine <= -$signed(mag);
    end else begin
      sine <= $signed(mag);
    end
  end

endmodule

[rtl/uv_sphere_vertex_generator.sv]
// uv sphere vertex generator: one grid point in, one vertex out, no stalls
// pipeline: result_valid follows the start cycle through 17 divider cells,
// 9 sine stages and 4 product and rounding stages; throughput one point per cycle
// busy stays low, the receiver cannot stall, results leave in acceptance order
// synchronous active high rst restores radius 256, 64 rings, 64 slices and
// empties the pipeline; config writes are taken whenever rst is low, ready is always high
module uv_sphere_vertex_generator #(
  parameter int DIVISION_BITS        = uvs_pkg::DIVISION_BITS_DEF,
  parameter int NORMAL_FRACTION_BITS = uvs_pkg::NORMAL_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         ring_number,
  input  logic [7:0]         slice_number,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               result_valid,
  output logic signed [24:0] pos_x,
  output logic signed [24:0] pos_y,
  output logic signed [24:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic [15:0]        vertex_index,
  output logic [15:0]        below_index,
  output logic               quad_start,
  output logic               point_valid
);

  // phase bits per full turn
  localparam int PB     = DIVISION_BITS + 8;
  localparam int DIV_N  = uvs_pkg::DIV_QW;
  // sine results line up with this sideband slot
  localparam int S_SIN  = DIV_N - 1 + uvs_pkg::SIN_LAT;
  localparam int SB_N   = S_SIN + 4;
  localparam int NSH    = 30 - NORMAL_FRACTION_BITS;
  localparam logic signed [63:0] NORM_LIM = (64'sd1 <<< NORMAL_FRACTION_BITS) - 64'sd1;

  // configuration registers
  logic [23:0] sphere_radius;
  logic [7:0]  ring_count;
  logic [7:0]  slice_count;

  logic accept;

  // sideband travelling alongside the arithmetic
  logic           vld [SB_N];
  uvs_pkg::band_t sb  [SB_N];
  uvs_pkg::band_t band_in;
  uvs_pkg::band_t band_div;

  // divider lanes: phi phase, theta phase, tex u, tex v
  logic [uvs_pkg::DIV_WW-1:0] dw [4][DIV_N+1];
  logic [uvs_pkg::DIV_DW-1:0] dv [4];

  logic [17:0] vidx_full;
  logic [31:0] phi32;
  logic [31:0] th32;

  logic signed [31:0] sp;
  logic signed [31:0] cp;
  logic signed [31:0] st;
  logic signed [31:0] ct;

  // product and rounding stages
  logic signed [63:0] prx;
  logic signed [63:0] prz;
  logic signed [31:0] cp1;
  logic signed [31:0] xq;
  logic signed [31:0] zq;
  logic signed [31:0] cp2;
  logic signed [56:0] rpx;
  logic signed [56:0] rpy;
  logic signed [56:0] rpz;
  logic [15:0]        nx;
  logic [15:0]        ny;
  logic [15:0]        nz;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 24'd256;
      ring_count    <= 8'd64;
      slice_count   <= 8'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        uvs_pkg::REG_RADIUS: sphere_radius <= cfg_data;
        uvs_pkg::REG_RINGS:  ring_count    <= cfg_data[7:0];
        uvs_pkg::REG_SLICES: slice_count   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // entry: dividends, divisors, indices and range flags
  always_comb begin
    dw[0][0] = (uvs_pkg::DIV_WW'(ring_number) << PB) + uvs_pkg::DIV_WW'(ring_count);
    dw[1][0] = (uvs_pkg::DIV_WW'(slice_number) << PB) + uvs_pkg::DIV_WW'(slice_count[7:1]);
    dw[2][0] = (uvs_pkg::DIV_WW'(slice_number) << 16) + uvs_pkg::DIV_WW'(slice_count[7:1]);
    dw[3][0] = (uvs_pkg::DIV_WW'(ring_number) << 16) + uvs_pkg::DIV_WW'(ring_count[7:1]);
    dv[0] = {ring_count, 1'b0};
    dv[1] = {1'b0, slice_count};
    dv[2] = {1'b0, slice_count};
    dv[3] = {1'b0, ring_count};

    vidx_full = 18'(ring_number) * 18'({1'b0, slice_count} + 9'd1) + 18'(slice_number);
    band_in.point_valid  = (ring_count != 8'd0) && (slice_count != 8'd0) &&
                           (ring_number <= ring_count) && (slice_number <= slice_count);
    band_in.quad_start   = band_in.point_valid && (ring_number < ring_count) &&
                           (slice_number < slice_count);
    band_in.vertex_index = vidx_full[15:0];
    band_in.below_index  = vidx_full[15:0] + 16'(slice_count) + 16'd1;
    band_in.tex_u        = '0;
    band_in.tex_v        = '0;
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    for (genvar c = 0; c < DIV_N; c++) begin : g_div
      uvs_div_cell u_div (
        .clk     (clk),
        .divisor (dv[l]),
        .din     (dw[l][c]),
        .dout    (dw[l][c+1])
      );
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SB_N; k++) vld[k] <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      vld[0] <= accept;
      for (int k = 1; k < SB_N; k++) vld[k] <= vld[k-1];
      result_valid <= vld[SB_N-1];
    end
  end

  // texture quotients join the sideband once the dividers finish
  always_comb begin
    band_div       = sb[DIV_N-1];
    band_div.tex_u = dw[2][DIV_N][uvs_pkg::DIV_QW-1:0];
    band_div.tex_v = dw[3][DIV_N][uvs_pkg::DIV_QW-1:0];
  end

  // sideband line
  always_ff @(posedge clk) begin
    sb[0] <= band_in;
    for (int k = 1; k < SB_N; k++) begin
      sb[k] <= (k == DIV_N) ? band_div : sb[k-1];
    end
  end

  // phases wrap at a full turn and scale to 32 bits per turn
  assign phi32 = 32'(dw[0][DIV_N][PB-1:0]) << (32 - PB);
  assign th32  = 32'(dw[1][DIV_N][PB-1:0]) << (32 - PB);

  uvs_sin_lane u_sin_phi (.clk(clk), .phase(phi32), .sine(sp));
  uvs_sin_lane u_cos_phi (.clk(clk), .phase(phi32 + uvs_pkg::QUARTER), .sine(cp));
  uvs_sin_lane u_sin_th  (.clk(clk), .phase(th32), .sine(st));
  uvs_sin_lane u_cos_th  (.clk(clk), .phase(th32 + uvs_pkg::QUARTER), .sine(ct));

  // sin(phi) times the azimuth terms
  always_ff @(posedge clk) begin
    prx <= sp * ct;
    prz <= sp * st;
    cp1 <= cp;
  end

  always_ff @(posedge clk) begin
    xq  <= 32'(uvs_pkg::rnd_shift(prx, 30));
    zq  <= 32'(uvs_pkg::rnd_shift(prz, 30));
    cp2 <= cp1;
  end

  // radius products and normals
  always_ff @(posedge clk) begin
    rpx <= $signed({1'b0, sphere_radius}) * xq;
    rpy <= $signed({1'b0, sphere_radius}) * cp2;
    rpz <= $signed({1'b0, sphere_radius}) * zq;
    nx  <= 16'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shift(64'(xq), NSH), NORM_LIM));
    ny  <= 16'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shift(64'(cp2), NSH), NORM_LIM));
    nz  <= 16'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shift(64'(zq), NSH), NORM_LIM));
  end

  // output register, every field zero for a point off the grid
  always_ff @(posedge clk) begin
    if (sb[SB_N-1].point_valid) begin
      pos_x <= 25'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shift(64'(rpx), 30), uvs_pkg::POS_LIM));
      pos_y <= 25'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shift(64'(rpy), 30), uvs_pkg::POS_LIM));
      pos_z <= 25'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shift(64'(rpz), 30), uvs_pkg::POS_LIM));
      norm_x       <= $signed(nx);
      norm_y       <= $signed(ny);
      norm_z       <= $signed(nz);
      tex_u        <= sb[SB_N-1].tex_u;
      tex_v        <= sb[SB_N-1].tex_v;
      vertex_index <= sb[SB_N-1].vertex_index;
      below_index  <= sb[SB_N-1].below_index;
      quad_start   <= sb[SB_N-1].quad_start;
      point_valid  <= 1'b1;
    end else begin
      pos_x        <= '0;
      pos_y        <= '0;
      pos_z        <= '0;
      norm_x       <= '0;
      norm_y       <= '0;
      norm_z       <= '0;
      tex_u        <= '0;
      tex_v        <= '0;
      vertex_index <= '0;
      below_index  <= '0;
      quad_start   <= 1'b0;
      point_valid  <= 1'b0;
    end
  end

endmodule
